/* rtl/core/pbwfs_pkg.sv */
// pbwfs_pkg: shared types, codes and constants of the protobuf wire field splitter
// no dependencies; imported by every other file of the block
`default_nettype none

package pbwfs_pkg;

  localparam int FIELD_W     = 29;
  localparam int VALUE_W     = 64;
  localparam int CFG_W       = 16;
  localparam int LENGTH_BITS = 16;
  localparam int POS_W       = 4;

  localparam logic [POS_W-1:0] VARINT_MAX_BYTES = POS_W'(9);
  localparam logic [POS_W-1:0] FIXED64_BYTES    = POS_W'(8);
  localparam logic [POS_W-1:0] FIXED32_BYTES    = POS_W'(4);
  localparam logic [CFG_W-1:0] MAX_LEN_RESET    = '1;

  // wire types from the low tag bits
  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LENGTH  = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  typedef enum logic [1:0] {
    KIND_SCALAR  = 2'd0,
    KIND_HEADER  = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_WIRE_TYPE = 3'd1,
    ERR_VARINT    = 3'd2,
    ERR_TRUNCATED = 3'd3,
    ERR_STR_LONG  = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_VARINT  = 3'd1,
    PH_FIXED   = 3'd2,
    PH_LENGTH  = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t                  phase;
    logic [VALUE_W-1:0]      acc;
    logic [POS_W-1:0]        pos;
    logic [FIELD_W-1:0]      field;
    logic [2:0]              wtype;
    logic [LENGTH_BITS-1:0]  bytes_left;
    logic                    skipping;
  } pbwfs_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eom;
  } pbwfs_byte_t;

  typedef struct packed {
    kind_t               kind;
    logic [FIELD_W-1:0]  field_number;
    logic [2:0]          wire_type;
    logic [VALUE_W-1:0]  value;
    logic [7:0]          payload_byte;
    logic                last_of_message;
    err_t                error_code;
  } pbwfs_result_t;

endpackage

`default_nettype wire

/* rtl/core/pbwfs_if.sv */
// pbwfs_in_if / pbwfs_out_if: valid-ready channels of the field splitter
// depends on pbwfs_pkg for field widths
`default_nettype none

interface pbwfs_in_if import pbwfs_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_message;

  modport source (output valid, output in_byte, output end_of_message, input ready);
  modport sink   (input valid, input in_byte, input end_of_message, output ready);
endinterface

interface pbwfs_out_if import pbwfs_pkg::*;;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [FIELD_W-1:0] field_number;
  logic [2:0]         wire_type;
  logic [VALUE_W-1:0] value;
  logic [7:0]         payload_byte;
  logic               last_of_message;
  logic [2:0]         error_code;

  modport source (output valid, output kind, output field_number, output wire_type,
                  output value, output payload_byte, output last_of_message,
                  output error_code, input ready);
  modport sink   (input valid, input kind, input field_number, input wire_type,
                  input value, input payload_byte, input last_of_message,
                  input error_code, output ready);
endinterface

`default_nettype wire

/* rtl/core/pbwfs_in_stage.sv */
// pbwfs_in_stage: input register for one message byte with its handshake
// depends on pbwfs_pkg and pbwfs_in_if
`default_nettype none

module pbwfs_in_stage import pbwfs_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  pbwfs_in_if.sink    message,
  input  wire logic   advance,
  output logic        held_valid,
  output pbwfs_byte_t held
);

  logic take;

  assign message.ready = !held_valid || advance;
  assign take          = message.valid && message.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held.data <= message.in_byte;
      held.eom  <= message.end_of_message;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pbwfs_decode.sv */
// pbwfs_decode: next parse state and result for one byte
// depends on pbwfs_pkg
`default_nettype none

module pbwfs_decode import pbwfs_pkg::*; (
  input  wire pbwfs_state_t     st,
  input  wire pbwfs_byte_t      in,
  input  wire logic [CFG_W-1:0] max_len,
  output pbwfs_state_t        st_next,
  output pbwfs_result_t       res,
  output logic                res_valid
);

  logic [5:0]         shamt_v;
  logic [VALUE_W-1:0] acc_v;
  logic [VALUE_W-1:0] acc_f;
  logic [POS_W-1:0]   pos_inc;
  logic               cont;
  logic               too_long;
  logic               fixed_done;
  logic [FIELD_W-1:0] tag_field;
  logic [2:0]         tag_type;
  logic               type_ok;
  logic               len_over;
  logic               len_zero;
  logic               more_left;

  assign shamt_v    = 6'({2'b00, st.pos} * 6'd7);
  assign acc_v      = st.acc | (VALUE_W'(in.data[6:0]) << shamt_v);
  assign acc_f      = st.acc | (VALUE_W'(in.data) << {st.pos[2:0], 3'b000});
  assign pos_inc    = st.pos + POS_W'(1);
  assign cont       = in.data[7];
  assign too_long   = cont && (pos_inc >= VARINT_MAX_BYTES);
  assign fixed_done = (st.wtype == WT_FIXED64) ? (pos_inc >= FIXED64_BYTES)
                                               : (pos_inc >= FIXED32_BYTES);
  assign tag_field  = acc_v[FIELD_W+2:3];
  assign tag_type   = acc_v[2:0];
  assign type_ok    = (tag_type == WT_VARINT) || (tag_type == WT_FIXED64) ||
                      (tag_type == WT_LENGTH) || (tag_type == WT_FIXED32);
  assign len_over   = acc_v > VALUE_W'(max_len);
  assign len_zero   = (acc_v == '0);
  assign more_left  = st.bytes_left > LENGTH_BITS'(1);

  // field finished: back to tag, keeps field and type
  function automatic pbwfs_state_t cleared(input pbwfs_state_t s);
    pbwfs_state_t r;
    r            = s;
    r.phase      = PH_TAG;
    r.acc        = '0;
    r.pos        = '0;
    r.bytes_left = '0;
    return r;
  endfunction

  function automatic pbwfs_result_t make_res(input kind_t k,
                                             input logic [FIELD_W-1:0] f,
                                             input logic [2:0] t,
                                             input logic [VALUE_W-1:0] v,
                                             input logic [7:0] pb,
                                             input logic last,
                                             input err_t e);
    pbwfs_result_t r;
    r.kind            = k;
    r.field_number    = f;
    r.wire_type       = t;
    r.value           = v;
    r.payload_byte    = pb;
    r.last_of_message = last;
    r.error_code      = e;
    return r;
  endfunction

  always_comb begin
    st_next   = st;
    res       = make_res(KIND_SCALAR, '0, '0, '0, '0, 1'b0, ERR_NONE);
    res_valid = 1'b0;

    if (st.skipping) begin
      if (in.eom) begin
        st_next          = cleared(st);
        st_next.skipping = 1'b0;
      end
    end else begin
      unique case (st.phase)
        PH_VARINT, PH_LENGTH: begin
          if (too_long) begin
            res_valid = 1'b1;
            res = make_res(KIND_ERROR, st.field, st.wtype, '0, '0, in.eom, ERR_VARINT);
          end else if (cont) begin
            if (in.eom) begin
              res_valid = 1'b1;
              res = make_res(KIND_ERROR, st.field, st.wtype, '0, '0, in.eom,
                             ERR_TRUNCATED);
            end else begin
              st_next.acc = acc_v;
              st_next.pos = pos_inc;
            end
          end else if (st.phase == PH_VARINT) begin
            res_valid = 1'b1;
            res = make_res(KIND_SCALAR, st.field, st.wtype, acc_v, '0, in.eom, ERR_NONE);
            st_next = cleared(st);
          end else if (len_over) begin
            res_valid = 1'b1;
            res = make_res(KIND_ERROR, st.field, st.wtype, '0, '0, in.eom, ERR_STR_LONG);
          end else if (!len_zero && in.eom) begin
            res_valid = 1'b1;
            res = make_res(KIND_ERROR, st.field, st.wtype, '0, '0, in.eom,
                           ERR_TRUNCATED);
          end else begin
            res_valid = 1'b1;
            res = make_res(KIND_HEADER, st.field, st.wtype, acc_v, '0, in.eom, ERR_NONE);
            st_next = cleared(st);
            if (!len_zero) begin
              st_next.phase      = PH_PAYLOAD;
              st_next.bytes_left = acc_v[LENGTH_BITS-1:0];
            end
          end
        end

        PH_FIXED: begin
          if (fixed_done) begin
            res_valid = 1'b1;
            res = make_res(KIND_SCALAR, st.field, st.wtype, acc_f, '0, in.eom, ERR_NONE);
            st_next = cleared(st);
          end else if (in.eom) begin
            res_valid = 1'b1;
            res = make_res(KIND_ERROR, st.field, st.wtype, '0, '0, in.eom,
                           ERR_TRUNCATED);
          end else begin
            st_next.acc = acc_f;
            st_next.pos = pos_inc;
          end
        end

        PH_PAYLOAD: begin
          res_valid = 1'b1;
          if (in.eom && more_left) begin
            res = make_res(KIND_ERROR, st.field, st.wtype, '0, '0, in.eom,
                           ERR_TRUNCATED);
          end else begin
            res = make_res(KIND_PAYLOAD, st.field, st.wtype, '0, in.data, in.eom,
                           ERR_NONE);
            if (more_left) begin
              st_next.bytes_left = st.bytes_left - LENGTH_BITS'(1);
            end else begin
              st_next = cleared(st);
            end
          end
        end

        default: begin
          // waiting for a tag
          if (too_long) begin
            res_valid = 1'b1;
            res = make_res(KIND_ERROR, '0, '0, '0, '0, in.eom, ERR_VARINT);
          end else if (cont) begin
            if (in.eom) begin
              res_valid = 1'b1;
              res = make_res(KIND_ERROR, '0, '0, '0, '0, in.eom, ERR_TRUNCATED);
            end else begin
              st_next.acc = acc_v;
              st_next.pos = pos_inc;
            end
          end else if (!type_ok) begin
            res_valid = 1'b1;
            res = make_res(KIND_ERROR, tag_field, tag_type, '0, '0, in.eom,
                           ERR_WIRE_TYPE);
          end else if (in.eom) begin
            res_valid = 1'b1;
            res = make_res(KIND_ERROR, tag_field, tag_type, '0, '0, in.eom,
                           ERR_TRUNCATED);
          end else begin
            st_next       = cleared(st);
            st_next.field = tag_field;
            st_next.wtype = tag_type;
            if (tag_type == WT_VARINT) begin
              st_next.phase = PH_VARINT;
            end else if (tag_type == WT_LENGTH) begin
              st_next.phase = PH_LENGTH;
            end else begin
              st_next.phase = PH_FIXED;
            end
          end
        end
      endcase

      // any error drops the field and skips to message end
      if (res_valid && (res.kind == KIND_ERROR)) begin
        st_next          = cleared(st);
        st_next.field    = '0;
        st_next.wtype    = '0;
        st_next.skipping = !in.eom;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/protobuf_wire_field_splitter.sv */
// protobuf_wire_field_splitter: top level, splits a protobuf wire stream into fields
// depends on pbwfs_pkg, pbwfs_if, pbwfs_in_stage and pbwfs_decode
`default_nettype none

//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+------------------------------------------
//  message   | in  | valid/ready        | in_byte, end_of_message
//  result    | out | valid/ready        | kind, field_number, wire_type, value,
//            |     |                    | payload_byte, last_of_message, error_code
//  cfg_wr_*  | in  | write enable only  | max_string_length (16 bit)
//
// one byte per cycle while result is not stalled: a request is held in the input
// register, then the decode logic updates the parse state and loads the result
// register from it
// a byte that yields no result still passes through the result stage
// back pressure on result stalls the input register and then message.ready
// rst (synchronous) returns the parser to waiting for a tag, limit to 65535

module protobuf_wire_field_splitter import pbwfs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  pbwfs_in_if.sink              message,
  pbwfs_out_if.source           result,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data
);

  logic          held_valid;
  pbwfs_byte_t   held;
  logic          advance;
  pbwfs_state_t  st;
  pbwfs_state_t  st_next;
  pbwfs_result_t res_next;
  logic          res_next_valid;
  pbwfs_result_t res;
  logic          res_valid;
  logic [CFG_W-1:0] max_string_length;

  // the held byte moves on when the result register is free or being drained
  assign advance = held_valid && (!res_valid || result.ready);

  pbwfs_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .message    (message),
    .advance    (advance),
    .held_valid (held_valid),
    .held       (held)
  );

  pbwfs_decode u_decode (
    .st        (st),
    .in        (held),
    .max_len   (max_string_length),
    .st_next   (st_next),
    .res       (res_next),
    .res_valid (res_next_valid)
  );

  // length limit register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      max_string_length <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_string_length <= cfg_wr_data;
    end
  end

  // parse state advances once per byte
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase      <= PH_TAG;
      st.acc        <= '0;
      st.pos        <= '0;
      st.field      <= '0;
      st.wtype      <= '0;
      st.bytes_left <= '0;
      st.skipping   <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= res_next_valid;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign result.valid           = res_valid;
  assign result.kind            = res.kind;
  assign result.field_number    = res.field_number;
  assign result.wire_type       = res.wire_type;
  assign result.value           = res.value;
  assign result.payload_byte    = res.payload_byte;
  assign result.last_of_message = res.last_of_message;
  assign result.error_code      = res.error_code;

endmodule

`default_nettype wire

/* tb/testbench.sv */
// testbench for protobuf_wire_field_splitter: byte stream in, decoded fields out
// depends on pbwfs_pkg and the pbwfs_in_if / pbwfs_out_if interfaces of the block
// a scoreboard class tracks parse state per accepted byte and checks every result

module testbench import pbwfs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 8;     // result stage plus margin, bytes without result
  localparam int QUIET_LIMIT  = 2000;  // cycles without any handshake before giving up
  localparam int PHASE_BYTES  = 150;
  localparam int HOLD_CYCLES  = 300;

  // wire types that the block must reject
  localparam logic [2:0] WT_GROUP_START = 3'd3;
  localparam logic [2:0] WT_GROUP_END   = 3'd4;
  localparam logic [2:0] WT_RESERVED6   = 3'd6;
  localparam logic [2:0] WT_RESERVED7   = 3'd7;

  typedef enum int {VB_MORE, VB_DONE, VB_LONG} vstep_t;
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // tracks the parse state and holds the fields still to come out of the block
  class field_tracker;
    pbwfs_result_t           expected_fields[$];
    logic [CFG_W-1:0]        max_len;
    int                      errors;
    phase_t                  ph;
    logic [VALUE_W-1:0]      acc;
    int unsigned             pos;
    logic [FIELD_W-1:0]      fld;
    logic [2:0]              wt;
    logic [LENGTH_BITS-1:0]  left;
    bit                      skip;

    function new();
      max_len = MAX_LEN_RESET;
      errors  = 0;
      fld     = '0;
      wt      = '0;
      skip    = 1'b0;
      clear_field();
    endfunction

    function void clear_field();
      ph   = PH_TAG;
      acc  = '0;
      pos  = 0;
      left = '0;
    endfunction

    function void push(kind_t k, logic [FIELD_W-1:0] f, logic [2:0] t,
                       logic [VALUE_W-1:0] v, logic [7:0] pb, logic last, err_t e);
      pbwfs_result_t r;
      r.kind            = k;
      r.field_number    = f;
      r.wire_type       = t;
      r.value           = v;
      r.payload_byte    = pb;
      r.last_of_message = last;
      r.error_code      = e;
      expected_fields.push_back(r);
    endfunction

    // error result, then drop bytes up to the message end unless this was it
    function void flag_error(logic [FIELD_W-1:0] f, logic [2:0] t, err_t e, logic last);
      push(KIND_ERROR, f, t, '0, '0, last, e);
      clear_field();
      fld  = '0;
      wt   = '0;
      skip = !last;
    endfunction

    function vstep_t add_varint(logic [7:0] b);
      acc |= VALUE_W'(b[6:0]) << (7 * pos);
      if (!b[7]) return VB_DONE;
      if (pos + 1 >= VARINT_MAX_BYTES) return VB_LONG;
      pos++;
      return VB_MORE;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      logic [FIELD_W-1:0] f;
      logic [2:0]         t;
      logic [FIELD_W-1:0] nf;
      logic [2:0]         nt;
      logic [VALUE_W-1:0] len;
      int unsigned        need;
      vstep_t             r;
      f = fld;
      t = wt;
      if (skip) begin
        if (last) begin
          skip = 1'b0;
          clear_field();
        end
        return;
      end
      case (ph)
        PH_VARINT: begin
          r = add_varint(b);
          if (r == VB_LONG) begin
            flag_error(f, t, ERR_VARINT, last);
          end else if (r == VB_MORE) begin
            if (last) flag_error(f, t, ERR_TRUNCATED, last);
          end else begin
            push(KIND_SCALAR, f, t, acc, '0, last, ERR_NONE);
            clear_field();
          end
        end
        PH_FIXED: begin
          need = (t == WT_FIXED64) ? FIXED64_BYTES : FIXED32_BYTES;
          acc |= VALUE_W'(b) << (8 * (pos & 7));
          pos++;
          if (pos >= need) begin
            push(KIND_SCALAR, f, t, acc, '0, last, ERR_NONE);
            clear_field();
          end else if (last) begin
            flag_error(f, t, ERR_TRUNCATED, last);
          end
        end
        PH_LENGTH: begin
          r = add_varint(b);
          if (r == VB_LONG) begin
            flag_error(f, t, ERR_VARINT, last);
          end else if (r == VB_MORE) begin
            if (last) flag_error(f, t, ERR_TRUNCATED, last);
          end else begin
            len = acc;
            if (len > VALUE_W'(max_len)) begin
              flag_error(f, t, ERR_STR_LONG, last);
            end else if (len != 0 && last) begin
              flag_error(f, t, ERR_TRUNCATED, last);
            end else begin
              push(KIND_HEADER, f, t, len, '0, last, ERR_NONE);
              clear_field();
              if (len != 0) begin
                ph   = PH_PAYLOAD;
                left = len[LENGTH_BITS-1:0];
              end
            end
          end
        end
        PH_PAYLOAD: begin
          if (last && left > 1) begin
            flag_error(f, t, ERR_TRUNCATED, last);
          end else begin
            push(KIND_PAYLOAD, f, t, '0, b, last, ERR_NONE);
            if (left <= 1) clear_field();
            else left = left - 1'b1;
          end
        end
        default: begin
          r = add_varint(b);
          if (r == VB_LONG) begin
            flag_error('0, '0, ERR_VARINT, last);
          end else if (r == VB_MORE) begin
            if (last) flag_error('0, '0, ERR_TRUNCATED, last);
          end else begin
            nf = acc[FIELD_W+2:3];
            nt = acc[2:0];
            if (!(nt == WT_VARINT || nt == WT_FIXED64 || nt == WT_LENGTH ||
                  nt == WT_FIXED32)) begin
              flag_error(nf, nt, ERR_WIRE_TYPE, last);
            end else if (last) begin
              flag_error(nf, nt, ERR_TRUNCATED, last);
            end else begin
              clear_field();
              fld = nf;
              wt  = nt;
              ph  = (nt == WT_VARINT) ? PH_VARINT : (nt == WT_LENGTH) ? PH_LENGTH : PH_FIXED;
            end
          end
        end
      endcase
    endfunction

    function void diff(string name, logic [63:0] want, logic [63:0] seen);
      if (want !== seen) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, seen);
        errors++;
      end
    endfunction

    function void compare_field(pbwfs_result_t got);
      pbwfs_result_t want;
      if (expected_fields.size() == 0) begin
        $display("%0t: result with nothing expected, actual kind %0d field %0h value %0h",
                 $time, got.kind, got.field_number, got.value);
        errors++;
        return;
      end
      want = expected_fields.pop_front();
      diff("kind", want.kind, got.kind);
      diff("field_number", want.field_number, got.field_number);
      diff("wire_type", want.wire_type, got.wire_type);
      diff("value", want.value, got.value);
      diff("payload_byte", want.payload_byte, got.payload_byte);
      diff("last_of_message", want.last_of_message, got.last_of_message);
      diff("error_code", want.error_code, got.error_code);
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  pbwfs_in_if  msg_if ();
  pbwfs_out_if res_if ();

  protobuf_wire_field_splitter u_top (
    .clk         (clk),
    .rst         (rst),
    .message     (msg_if),
    .result      (res_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  field_tracker  sb;
  pbwfs_byte_t   frame_bytes[$];   // the message being built, sent as a unit
  pbwfs_result_t seen_field;
  int            send_idle_pct  = 0;
  int            recv_stall_pct = 0;
  int            hold_ask       = 0;   // set by the main flow, taken by the receiver
  int            hold_left      = 0;
  int            quiet_cycles   = 0;

  // clock, 10 ns period
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off counted here
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ask > 0) begin
        hold_left = hold_ask;
        hold_ask  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (msg_if.valid && msg_if.ready)
        sb.take_byte(msg_if.in_byte, msg_if.end_of_message);
      if (res_if.valid && res_if.ready) begin
        seen_field.kind            = kind_t'(res_if.kind);
        seen_field.field_number    = res_if.field_number;
        seen_field.wire_type       = res_if.wire_type;
        seen_field.value           = res_if.value;
        seen_field.payload_byte    = res_if.payload_byte;
        seen_field.last_of_message = res_if.last_of_message;
        seen_field.error_code      = err_t'(res_if.error_code);
        sb.compare_field(seen_field);
      end
    end
  end

  // watchdog: too long with no request and no result moving
  always @(posedge clk) begin
    if ((msg_if.valid && msg_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  function void put_byte(logic [7:0] b);
    pbwfs_byte_t x;
    x.data = b;
    x.eom  = 1'b0;
    frame_bytes.push_back(x);
  endfunction

  // minimal encoding, optionally stretched with zero continuation groups
  function void put_varint(logic [63:0] v, int pad);
    int n;
    n = 1;
    while (n < 9 && (v >> (7 * n)) != 0) n++;
    n = n + pad;
    if (n > 9) n = 9;
    for (int i = 0; i < n; i++) put_byte({i < n - 1, 7'(v >> (7 * i))});
  endfunction

  function void put_tag(logic [FIELD_W-1:0] fn, logic [2:0] wt);
    put_varint({32'b0, fn, wt}, 0);
  endfunction

  function int rand_pad();
    return ($urandom_range(9) == 0) ? $urandom_range(3, 1) : 0;
  endfunction

  function logic [63:0] rand_bits(int w);
    logic [63:0] r;
    r = {$urandom, $urandom};
    if (w <= 0) return '0;
    if (w >= 64) return r;
    return r & ((64'd1 << w) - 1);
  endfunction

  // lengths around the current limit, mostly small ones
  function logic [63:0] pick_length();
    int r;
    int cap;
    r   = $urandom_range(9);
    cap = (sb.max_len < 6) ? sb.max_len : 6;
    if (r < 6) return 64'($urandom_range(cap));
    if (r == 6) return (sb.max_len <= 64) ? 64'(sb.max_len) : 64'($urandom_range(40));
    if (r == 7) return 64'(sb.max_len) + 1;
    if (r == 8) return rand_bits($urandom_range(63, 17)) | (64'd1 << 16);
    return 64'($urandom_range((sb.max_len < 40) ? sb.max_len : 40));
  endfunction

  function void put_field();
    int                 pick;
    int                 r;
    logic [FIELD_W-1:0] fn;
    logic [2:0]         wt;
    logic [63:0]        tag;
    logic [63:0]        len;
    pick = $urandom_range(99);
    r    = $urandom_range(9);
    if (r == 0) fn = '0;
    else if (r == 1) fn = '1;
    else if (r < 6) fn = FIELD_W'($urandom_range(15, 1));
    else fn = FIELD_W'(rand_bits($urandom_range(29, 1)));
    if (pick < 35) wt = WT_VARINT;
    else if (pick < 50) wt = WT_FIXED64;
    else if (pick < 65) wt = WT_FIXED32;
    else if (pick < 93) wt = WT_LENGTH;
    else if (pick < 97) begin
      case ($urandom_range(3))
        0: wt = WT_GROUP_START;
        1: wt = WT_GROUP_END;
        2: wt = WT_RESERVED6;
        default: wt = WT_RESERVED7;
      endcase
    end else wt = WT_VARINT;
    // over-long varint, either as the tag or as the value
    if (pick >= 97) begin
      if ($urandom_range(1)) put_tag(fn, wt);
      for (int i = 0; i < 9; i++) put_byte(8'h80 | 8'($urandom));
      return;
    end
    tag = {32'b0, fn, wt};
    if ($urandom_range(19) == 0) tag[62:32] = 31'($urandom);  // high bits beyond the field
    put_varint(tag, rand_pad());
    if (wt == WT_VARINT) begin
      put_varint(rand_bits($urandom_range(63)), rand_pad());
    end else if (wt == WT_FIXED64) begin
      for (int i = 0; i < 8; i++) put_byte(8'($urandom));
    end else if (wt == WT_FIXED32) begin
      for (int i = 0; i < 4; i++) put_byte(8'($urandom));
    end else if (wt == WT_LENGTH) begin
      len = pick_length();
      put_varint(len, rand_pad());
      if (len <= 64'(sb.max_len))
        for (int i = 0; i < int'(len); i++) put_byte(8'($urandom));
    end else begin
      // junk after a rejected tag is skipped
      for (int i = 0; i < $urandom_range(2); i++) put_byte(8'($urandom));
    end
  endfunction

  // well-formed messages mostly, some cut short, some pure noise
  function void build_message();
    int r;
    r = $urandom_range(99);
    frame_bytes.delete();
    if (r < 8) begin
      for (int i = 0; i < $urandom_range(8, 1); i++) put_byte(8'($urandom));
    end else begin
      for (int i = 0; i < $urandom_range(4, 1); i++) put_field();
      if (r < 23 && frame_bytes.size() > 1) begin
        int cut;
        cut = $urandom_range(frame_bytes.size() - 2);
        while (frame_bytes.size() > cut + 1) void'(frame_bytes.pop_back());
      end
    end
  endfunction

  // one request: optional idle cycles, then hold until taken; ends at a falling edge
  task automatic send_byte(pbwfs_byte_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      msg_if.valid <= 1'b0;
      @(negedge clk);
    end
    msg_if.valid          <= 1'b1;
    msg_if.in_byte        <= item.data;
    msg_if.end_of_message <= item.eom;
    do @(posedge clk); while (!msg_if.ready);
    @(negedge clk);
  endtask

  task automatic send_message();
    frame_bytes[frame_bytes.size() - 1].eom = 1'b1;
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
    frame_bytes.delete();
  endtask

  task automatic run_phase(idle_mode_t mode, int n_bytes);
    int sent;
    sent = 0;
    case (mode)
      IDLE_SEND: begin send_idle_pct = 83; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 83; end
      IDLE_BOTH: begin send_idle_pct = 25; recv_stall_pct = 25; end
      default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
    while (sent < n_bytes) begin
      build_message();
      sent += frame_bytes.size();
      send_message();
    end
    msg_if.valid <= 1'b0;
  endtask

  // all results out, then let bytes without a result clear the pipe
  task automatic wait_quiet();
    while (sb.expected_fields.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(logic [CFG_W-1:0] v);
    wait_quiet();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.max_len = v;
  endtask

  initial begin
    sb = new();
    rst                   = 1'b1;
    cfg_wr_en             = 1'b0;
    cfg_wr_data           = '0;
    msg_if.valid          = 1'b0;
    msg_if.in_byte        = '0;
    msg_if.end_of_message = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // scalar 150 then an empty string closing the message
    put_tag(29'd1, WT_VARINT);
    put_varint(64'd150, 0);
    put_tag(29'd0, WT_LENGTH);
    put_varint(64'd0, 0);
    send_message();
    // largest field number
    put_tag('1, WT_VARINT);
    put_varint(64'd127, 0);
    send_message();
    // rejected wire type, rest skipped
    put_tag(29'd1, WT_GROUP_START);
    put_byte(8'h00);
    send_message();
    // payload cut short: header, then truncation
    put_tag(29'd2, WT_LENGTH);
    put_varint(64'd2, 0);
    put_byte(8'hAA);
    send_message();
    // length above the limit
    put_tag(29'd2, WT_LENGTH);
    put_varint(64'd65536, 0);
    send_message();
    // value varint ends mid-way
    put_byte(8'h08);
    put_byte(8'h80);
    send_message();
    // tag varint too long
    for (int i = 0; i < 9; i++) put_byte(8'hFF);
    send_message();
    msg_if.valid <= 1'b0;

    run_phase(IDLE_NONE, PHASE_BYTES);
    write_limit('0);
    run_phase(IDLE_SEND, PHASE_BYTES);
    write_limit(16'd1);
    run_phase(IDLE_RECV, PHASE_BYTES);
    write_limit(CFG_W'($urandom_range(64, 2)));
    run_phase(IDLE_BOTH, PHASE_BYTES);
    write_limit(MAX_LEN_RESET);
    // receiver holds off while requests keep coming, so the block backs up
    hold_ask = HOLD_CYCLES;
    run_phase(IDLE_NONE, PHASE_BYTES);

    wait_quiet();
    if (sb.errors == 0 && sb.expected_fields.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
